// ----- design/bitmap_and_rank_offsets_assert.svh -----
// assertion macros used by the checker file bro_checker.sv
// each macro expects clk and arst_n to be visible where it is used
`ifndef BITMAP_AND_RANK_OFFSETS_ASSERT_SVH
`define BITMAP_AND_RANK_OFFSETS_ASSERT_SVH

// same-cycle implication
`define BRO_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bro assertion failed");

// next-cycle implication
`define BRO_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bro assertion failed");

`endif

// ----- design/bro_pkg.sv -----
// ----------------------------------------------------------------------------
// bro_pkg
// shared widths and types of the bitmap intersection / rank block
// ----------------------------------------------------------------------------
package bro_pkg;

	localparam int WORD_BITS = 64;   // bits of each word taken into account
	localparam int WORD_W    = 64;   // width of the word fields
	localparam int BASE_W    = 24;
	localparam int RANK_W    = 25;

	typedef struct packed {
		logic              valid;
		logic [RANK_W-1:0] rank_a;
		logic [RANK_W-1:0] rank_b;
		logic              last;
	} hit_t;

endpackage

// ----- design/bro_in_if.sv -----
// ----------------------------------------------------------------------------
// bro_in_if
// input channel: two bitmap words and two base offsets
// ----------------------------------------------------------------------------
interface bro_in_if;
	logic                      valid;
	logic                      ready;
	logic [bro_pkg::WORD_W-1:0] word_a;
	logic [bro_pkg::WORD_W-1:0] word_b;
	logic [bro_pkg::BASE_W-1:0] base_a;
	logic [bro_pkg::BASE_W-1:0] base_b;

	modport source(output valid, output word_a, output word_b, output base_a,
		output base_b, input ready);
	modport sink(input valid, input word_a, input word_b, input base_a,
		input base_b, output ready);
endinterface

// ----- design/bro_out_if.sv -----
// ----------------------------------------------------------------------------
// bro_out_if
// result channel: rank pair per common bit, last mark
// ----------------------------------------------------------------------------
interface bro_out_if;
	logic                      valid;
	logic                      ready;
	logic [bro_pkg::RANK_W-1:0] rank_a;
	logic [bro_pkg::RANK_W-1:0] rank_b;
	logic                      last;

	modport source(output valid, output rank_a, output rank_b, output last,
		input ready);
	modport sink(input valid, input rank_a, input rank_b, input last,
		output ready);
endinterface

// ----- design/bro_scan.sv -----
// ----------------------------------------------------------------------------
// bro_scan
// bit-serial scanner: one position per cycle unless a hit waits; rank counters
// ----------------------------------------------------------------------------
module bro_scan (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [bro_pkg::WORD_W-1:0] word_a,
	input  logic [bro_pkg::WORD_W-1:0] word_b,
	input  logic [bro_pkg::BASE_W-1:0] base_a,
	input  logic [bro_pkg::BASE_W-1:0] base_b,
	input  logic                       slot_free,
	output logic                       busy,
	output bro_pkg::hit_t              hit
);

	logic                          busy_q;
	logic [bro_pkg::WORD_BITS-1:0] wa_q;
	logic [bro_pkg::WORD_BITS-1:0] wb_q;
	logic [bro_pkg::RANK_W-1:0]    cnt_a_q;
	logic [bro_pkg::RANK_W-1:0]    cnt_b_q;

	logic                          common_bit;
	logic                          more_common;
	logic                          advance;
	logic [bro_pkg::WORD_BITS-1:0] common_rest;

	assign common_bit  = wa_q[0] & wb_q[0];
	assign common_rest = (wa_q & wb_q) >> 1;
	assign more_common = |common_rest;
	// a position with a hit waits until the output slot can take it
	assign advance     = busy_q && (!common_bit || slot_free);

	assign busy        = busy_q;
	assign hit.valid   = busy_q && common_bit;
	assign hit.rank_a  = cnt_a_q;
	assign hit.rank_b  = cnt_b_q;
	assign hit.last    = !more_common;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
		end else if (advance && !more_common) begin
			busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			// bits above WORD_BITS are dropped here
			wa_q    <= word_a[bro_pkg::WORD_BITS-1:0];
			wb_q    <= word_b[bro_pkg::WORD_BITS-1:0];
			cnt_a_q <= {1'b0, base_a};
			cnt_b_q <= {1'b0, base_b};
		end else if (advance) begin
			wa_q    <= wa_q >> 1;
			wb_q    <= wb_q >> 1;
			cnt_a_q <= cnt_a_q + bro_pkg::RANK_W'(wa_q[0]);
			cnt_b_q <= cnt_b_q + bro_pkg::RANK_W'(wb_q[0]);
		end
	end

endmodule

// ----- design/bro_out_stage.sv -----
// ----------------------------------------------------------------------------
// bro_out_stage
// output register between the scanner and the result channel
// ----------------------------------------------------------------------------
module bro_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  bro_pkg::hit_t      hit,
	output logic               slot_free,
	bro_out_if.source          results
);

	logic                       valid_q;
	logic [bro_pkg::RANK_W-1:0] rank_a_q;
	logic [bro_pkg::RANK_W-1:0] rank_b_q;
	logic                       last_q;

	assign slot_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= hit.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && hit.valid) begin
			rank_a_q <= hit.rank_a;
			rank_b_q <= hit.rank_b;
			last_q   <= hit.last;
		end
	end

	assign results.valid  = valid_q;
	assign results.rank_a = rank_a_q;
	assign results.rank_b = rank_b_q;
	assign results.last   = last_q;

endmodule

// ----- design/bitmap_and_rank_offsets.sv -----
// ----------------------------------------------------------------------------
// bitmap_and_rank_offsets
// intersection of two bitmap words with rank offsets per common bit
// ----------------------------------------------------------------------------
// a result is taken into the output register from the scanner when it reaches
// a common bit; the scanner holds at that bit until the output slot is free
// the scanner takes one bit position per cycle up to the highest common bit,
// waiting at a hit while the output slot is full, and ends the item there
// the input is not ready while the scanner holds an item
// reset clears the scanner busy flag and the output valid, nothing else
module bitmap_and_rank_offsets (
	input  logic      clk,
	input  logic      arst_n,
	bro_in_if.sink    items,
	bro_out_if.source results
);

	logic          busy;
	logic          slot_free;
	logic          start;
	bro_pkg::hit_t hit;

	assign items.ready = !busy;
	assign start       = items.valid && !busy;

	bro_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.word_a    (items.word_a),
		.word_b    (items.word_b),
		.base_a    (items.base_a),
		.base_b    (items.base_b),
		.slot_free (slot_free),
		.busy      (busy),
		.hit       (hit)
	);

	bro_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.hit       (hit),
		.slot_free (slot_free),
		.results   (results)
	);

endmodule

// ----- design/bro_checker.sv -----
// ----------------------------------------------------------------------------
// bro_checker
// port-level checks of the bitmap intersection / rank block
// ----------------------------------------------------------------------------
`include "bitmap_and_rank_offsets_assert.svh"

module bro_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_valid,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [bro_pkg::RANK_W-1:0] out_rank_a,
	input logic [bro_pkg::RANK_W-1:0] out_rank_b,
	input logic                       out_last
);

	// one item at a time
	`BRO_ASSERT_NXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

	// a result that is not the last means the item is still in work
	`BRO_ASSERT_IMP(a_not_last_busy, out_valid && !out_last, !in_ready)

	`BRO_ASSERT_NXT(a_valid_holds, out_valid && !out_ready, out_valid)

	`BRO_ASSERT_NXT(a_payload_holds, out_valid && !out_ready,
		$stable(out_rank_a) && $stable(out_rank_b) && $stable(out_last))

endmodule

bind bitmap_and_rank_offsets bro_checker u_bro_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (items.valid),
	.in_ready   (items.ready),
	.out_valid  (results.valid),
	.out_ready  (results.ready),
	.out_rank_a (results.rank_a),
	.out_rank_b (results.rank_b),
	.out_last   (results.last)
);
